// ----- rtl/core/lpfp_pkg.sv -----
// shared constants, result type and helpers for the length-prefixed frame parser
package lpfp_pkg;

    localparam int HDR_WORDS  = 5;
    localparam int HDR_BYTES  = HDR_WORDS * 4;
    localparam int HW_IDX_W   = $clog2(HDR_WORDS);
    localparam int LEN_W      = 24;
    localparam int WORD_W     = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [LEN_W-1:0] MAX_FRAME_RESET = LEN_W'(1024 * 1024);

    // register word index taken from the byte address
    localparam logic REG_MAX_FRAME = 1'b0;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic ERR_TOO_LONG  = 1'b0;
    localparam logic ERR_HDR_SHORT = 1'b1;

    typedef struct packed {
        logic [1:0]        kind;
        logic              error_code;
        logic [WORD_W-1:0] cmd_id;
        logic [WORD_W-1:0] seq_num;
        logic [LEN_W-1:0]  body_len;
        logic [LEN_W-1:0]  frame_length;
        logic [7:0]        data_byte;
        logic              last;
    } t_result;

    function automatic logic [LEN_W-1:0] sat24(input logic [WORD_W:0] v);
        logic [LEN_W-1:0] r;
        r = (|v[WORD_W:LEN_W]) ? {LEN_W{1'b1}} : v[LEN_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/core/lpfp_in_if.sv -----
// input byte channel
interface lpfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       restart;

    modport source (output valid, output rx_byte, output restart, input ready);
    modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

// ----- rtl/core/lpfp_out_if.sv -----
// result channel
interface lpfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        error_code;
    logic [31:0] cmd_id;
    logic [31:0] seq_num;
    logic [23:0] body_len;
    logic [23:0] frame_length;
    logic [7:0]  data_byte;
    logic        last;

    modport source (output valid, output kind, output error_code, output cmd_id,
                    output seq_num, output body_len, output frame_length,
                    output data_byte, output last, input ready);
    modport sink   (input valid, input kind, input error_code, input cmd_id,
                    input seq_num, input body_len, input frame_length,
                    input data_byte, input last, output ready);
endinterface

// ----- rtl/core/lpfp_cfg.sv -----
// apb register block holding the maximum frame length
module lpfp_cfg import lpfp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [LEN_W-1:0]      o_max_frame
);

    logic [LEN_W-1:0] r_max_frame;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_FRAME);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame <= MAX_FRAME_RESET;
        end else if (wr_en) begin
            r_max_frame <= pwdata[LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_FRAME) begin
            prdata = {{(APB_DATA_W-LEN_W){1'b0}}, r_max_frame};
        end
    end

    assign o_max_frame = r_max_frame;

endmodule

// ----- rtl/core/lpfp_core.sv -----
// header capture, length checks and body byte tracking, one beat per cycle while i_beat is high
module lpfp_core import lpfp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_beat,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_restart,
    input  logic [LEN_W-1:0] i_max_frame,
    output logic             o_push,
    output t_result          o_res
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_EXT    = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;
    localparam logic [1:0] PH_ERROR  = 2'd3;

    logic [1:0]        r_phase, n_phase;
    logic [LEN_W-1:0]  r_count, n_count, count_inc;
    logic [LEN_W-1:0]  r_frame;
    logic [WORD_W-1:0] r_hw [HDR_WORDS];

    logic [HW_IDX_W-1:0] wsel;
    logic                hw_we;
    logic                frame_we;
    logic [WORD_W-1:0]   hw4_new;
    logic [WORD_W:0]     frame_sum;
    logic                too_long;
    logic                too_short;
    logic                hdr_done;
    logic                body_last;

    assign count_inc = r_count + LEN_W'(1);
    assign wsel      = r_count[HW_IDX_W+1:2];
    // body length word as it stands once the final header byte lands
    assign hw4_new   = {r_hw[HDR_WORDS-1][WORD_W-9:0], i_rx_byte};
    assign frame_sum = {1'b0, r_hw[0]} + {1'b0, hw4_new};
    assign too_long  = frame_sum > {{(WORD_W+1-LEN_W){1'b0}}, i_max_frame};
    assign too_short = r_hw[0] < WORD_W'(HDR_BYTES);
    assign hdr_done  = r_count == LEN_W'(HDR_BYTES - 1);
    assign body_last = count_inc >= r_frame;

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        hw_we    = 1'b0;
        frame_we = 1'b0;
        o_push   = 1'b0;
        o_res.kind         = KIND_HEADER;
        o_res.error_code   = ERR_TOO_LONG;
        o_res.cmd_id       = r_hw[2];
        o_res.seq_num      = r_hw[3];
        o_res.body_len     = r_hw[HDR_WORDS-1][LEN_W-1:0];
        o_res.frame_length = r_frame;
        o_res.data_byte    = '0;
        o_res.last         = 1'b0;
        if (i_beat) begin
            if (i_restart) begin
                n_phase = PH_HEADER;
                n_count = '0;
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        hw_we   = 1'b1;
                        n_count = count_inc;
                        if (hdr_done) begin
                            o_push             = 1'b1;
                            o_res.body_len     = sat24({1'b0, hw4_new});
                            o_res.frame_length = sat24(frame_sum);
                            if (too_long) begin
                                o_res.kind       = KIND_ERROR;
                                o_res.error_code = ERR_TOO_LONG;
                                n_phase          = PH_ERROR;
                            end else if (too_short) begin
                                o_res.kind       = KIND_ERROR;
                                o_res.error_code = ERR_HDR_SHORT;
                                n_phase          = PH_ERROR;
                            end else begin
                                o_res.kind = KIND_HEADER;
                                o_res.last = (hw4_new == '0);
                                frame_we   = 1'b1;
                                if (r_hw[0] > WORD_W'(HDR_BYTES)) begin
                                    n_phase = PH_EXT;
                                end else if (hw4_new != '0) begin
                                    n_phase = PH_BODY;
                                end else begin
                                    n_phase = PH_HEADER;
                                    n_count = '0;
                                end
                            end
                        end
                    end
                    PH_EXT: begin
                        n_count = count_inc;
                        // frame passed the check, so header length fits 24 bits
                        if (count_inc >= r_hw[0][LEN_W-1:0]) begin
                            if (r_hw[HDR_WORDS-1] != '0) begin
                                n_phase = PH_BODY;
                            end else begin
                                n_phase = PH_HEADER;
                                n_count = '0;
                            end
                        end
                    end
                    PH_BODY: begin
                        o_push          = 1'b1;
                        o_res.kind      = KIND_BODY;
                        o_res.data_byte = i_rx_byte;
                        o_res.last      = body_last;
                        if (body_last) begin
                            n_phase = PH_HEADER;
                            n_count = '0;
                        end else begin
                            n_count = count_inc;
                        end
                    end
                    default: begin
                        // error phase swallows beats until restart
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hw_we) begin
            r_hw[wsel] <= {r_hw[wsel][WORD_W-9:0], i_rx_byte};
        end
        if (frame_we) begin
            r_frame <= frame_sum[LEN_W-1:0];
        end
    end

    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> r_count < LEN_W'(HDR_BYTES))
        else $error("header byte count ran past the header");

    a_err_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_res.kind == KIND_ERROR |=> r_phase == PH_ERROR)
        else $error("error beat did not enter the error phase");

    a_body_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> r_count < r_frame)
        else $error("body count reached frame length without last");

endmodule

// ----- rtl/core/lpfp_obuf.sv -----
// two-entry output stage: result register plus skid slot
module lpfp_obuf import lpfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_out_v, r_skid_v;
    t_result r_out, r_skid;
    logic    pop;

    assign pop     = r_out_v && i_ready;
    assign o_room  = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || pop) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= i_push;
            end
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || pop) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_res;
            end
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid slot filled while result register empty");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !i_ready |=> r_out_v)
        else $error("stalled result dropped");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_v)
        else $error("result pushed with no room");

endmodule

// ----- rtl/core/length_prefixed_frame_parser.sv -----
// top level of the length-prefixed frame parser
//
//  port       dir  role      contents
//  i_in       in   sink      rx_byte, restart
//  o_out      out  source    kind, error_code, cmd_id, seq_num, body_len,
//                            frame_length, data_byte, last
//  apb        in   slave     max_frame_length at byte address 0
//
// one beat per cycle while the output stage has room: each byte is handled by
// the state update between the capture registers and the output stage
// the two-entry output stage keeps i_in.ready high while a single result waits;
// ready drops only when both entries are full
// synchronous active-low reset returns to header hunt with an empty output stage
module length_prefixed_frame_parser import lpfp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lpfp_in_if.sink               i_in,
    lpfp_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic             max_room;
    logic             beat;
    logic             push;
    logic [LEN_W-1:0] max_frame;
    t_result          core_res;
    t_result          out_res;

    assign i_in.ready = max_room;
    assign beat       = i_in.valid && max_room;

    lpfp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_max_frame (max_frame)
    );

    lpfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (beat),
        .i_rx_byte   (i_in.rx_byte),
        .i_restart   (i_in.restart),
        .i_max_frame (max_frame),
        .o_push      (push),
        .o_res       (core_res)
    );

    lpfp_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (core_res),
        .o_room  (max_room),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (out_res)
    );

    assign o_out.kind         = out_res.kind;
    assign o_out.error_code   = out_res.error_code;
    assign o_out.cmd_id       = out_res.cmd_id;
    assign o_out.seq_num      = out_res.seq_num;
    assign o_out.body_len     = out_res.body_len;
    assign o_out.frame_length = out_res.frame_length;
    assign o_out.data_byte    = out_res.data_byte;
    assign o_out.last         = out_res.last;

endmodule
